// File: rtl/lprp_pkg.sv
// ----------------------------------------------------------------------------
// Record parser package
// Field widths, byte-role codes and the item types used by the parser.
// ----------------------------------------------------------------------------
package lprp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned RoleW  = 3;
  localparam int unsigned LenW   = 32;
  localparam int unsigned SeqW   = 64;
  localparam int unsigned CountW = 3;

  // Byte roles, which double as the parser phase codes.
  localparam logic [RoleW-1:0] PH_KLEN = 3'd0;
  localparam logic [RoleW-1:0] PH_KEY  = 3'd1;
  localparam logic [RoleW-1:0] PH_TYPE = 3'd2;
  localparam logic [RoleW-1:0] PH_SEQ  = 3'd3;
  localparam logic [RoleW-1:0] PH_VLEN = 3'd4;
  localparam logic [RoleW-1:0] PH_VAL  = 3'd5;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic [RoleW-1:0] byte_role;
    logic [ByteW-1:0] byte_out;
    logic             record_complete;
    logic [ByteW-1:0] entry_type;
    logic [SeqW-1:0]  sequence_number;
    logic [LenW-1:0]  key_length;
    logic [LenW-1:0]  value_length;
    logic             block_done;
    logic             partial_dropped;
  } result_t;

endpackage

// File: rtl/lprp_in_if.sv
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one data block byte per item.
// ----------------------------------------------------------------------------
interface lprp_in_if import lprp_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

// File: rtl/lprp_out_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one parse result per item.
// ----------------------------------------------------------------------------
interface lprp_out_if import lprp_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [RoleW-1:0] byte_role;
  logic [ByteW-1:0] byte_out;
  logic             record_complete;
  logic [ByteW-1:0] entry_type;
  logic [SeqW-1:0]  sequence_number;
  logic [LenW-1:0]  key_length;
  logic [LenW-1:0]  value_length;
  logic             block_done;
  logic             partial_dropped;

  modport source (
    output valid, output byte_role, output byte_out, output record_complete,
    output entry_type, output sequence_number, output key_length,
    output value_length, output block_done, output partial_dropped,
    input ready
  );
  modport sink (
    input valid, input byte_role, input byte_out, input record_complete,
    input entry_type, input sequence_number, input key_length,
    input value_length, input block_done, input partial_dropped,
    output ready
  );

endinterface

// File: rtl/lprp_in_stage.sv
// ----------------------------------------------------------------------------
// Input register stage
// Captures one byte item and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module lprp_in_stage import lprp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  lprp_in_if.sink       item_i,
  input  logic          take_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;

  // The register frees up in the same cycle that the parser takes its item.
  assign item_i.ready = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (item_i.valid && item_i.ready) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.data_byte <= item_i.data_byte;
      item_q.last_byte <= item_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/lprp_parser.sv
// ----------------------------------------------------------------------------
// Record parser core
// Holds the record state and decodes the role of each byte it is given.
// ----------------------------------------------------------------------------
module lprp_parser import lprp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  in_item_t item_i,
  output result_t  result_o
);

  logic [RoleW-1:0]  phase_q,  phase_d,  phase_eff;
  logic [CountW-1:0] count_q,  count_d;
  logic [LenW-1:0]   remain_q, remain_d;
  logic [LenW-1:0]   klen_q,   klen_d;
  logic [ByteW-1:0]  type_q,   type_d;
  logic [SeqW-1:0]   seq_q,    seq_d;
  logic [LenW-1:0]   vlen_q,   vlen_d;
  logic              done;
  logic [LenW-1:0]   byte_len;
  logic [SeqW-1:0]   byte_seq;

  assign byte_len = LenW'(item_i.data_byte);
  assign byte_seq = SeqW'(item_i.data_byte);

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    remain_d  = remain_q;
    klen_d    = klen_q;
    type_d    = type_q;
    seq_d     = seq_q;
    vlen_d    = vlen_q;
    done      = 1'b0;
    phase_eff = (phase_q > PH_VAL) ? PH_KLEN : phase_q;

    unique case (phase_eff)
      PH_KLEN: begin
        klen_d = klen_q | (byte_len << {count_q[1:0], 3'b000});
        if (count_q[1:0] == 2'd3) begin
          count_d  = '0;
          remain_d = klen_d;
          phase_d  = (klen_d == '0) ? PH_TYPE : PH_KEY;
        end else begin
          count_d = count_q + 1'b1;
          phase_d = PH_KLEN;
        end
      end
      PH_KEY: begin
        remain_d = remain_q - 1'b1;
        if (remain_d == '0) begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d  = item_i.data_byte;
        count_d = '0;
        phase_d = PH_SEQ;
      end
      PH_SEQ: begin
        seq_d = seq_q | (byte_seq << {count_q, 3'b000});
        if (count_q == 3'd7) begin
          count_d = '0;
          phase_d = PH_VLEN;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      PH_VLEN: begin
        vlen_d = vlen_q | (byte_len << {count_q[1:0], 3'b000});
        if (count_q[1:0] == 2'd3) begin
          count_d  = '0;
          remain_d = vlen_d;
          if (vlen_d == '0) begin
            done = 1'b1;
          end else begin
            phase_d = PH_VAL;
          end
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      PH_VAL: begin
        remain_d = remain_q - 1'b1;
        if (remain_d == '0) begin
          done = 1'b1;
        end
      end
      default: begin
        phase_d = PH_KLEN;
      end
    endcase

    result_o.byte_role       = phase_eff;
    result_o.byte_out        = item_i.data_byte;
    result_o.record_complete = done;
    result_o.entry_type      = done ? type_d : '0;
    result_o.sequence_number = done ? seq_d : '0;
    result_o.key_length      = done ? klen_d : '0;
    result_o.value_length    = done ? vlen_d : '0;
    result_o.block_done      = item_i.last_byte;
    result_o.partial_dropped = item_i.last_byte && !done;

    // A finished record or the end of the block returns the parser to reset.
    if (done || item_i.last_byte) begin
      phase_d  = PH_KLEN;
      count_d  = '0;
      remain_d = '0;
      klen_d   = '0;
      type_d   = '0;
      seq_d    = '0;
      vlen_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_KLEN;
      count_q  <= '0;
      remain_q <= '0;
      klen_q   <= '0;
      type_q   <= '0;
      seq_q    <= '0;
      vlen_q   <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      klen_q   <= klen_d;
      type_q   <= type_d;
      seq_q    <= seq_d;
      vlen_q   <= vlen_d;
    end
  end

endmodule

// File: rtl/lprp_out_stage.sv
// ----------------------------------------------------------------------------
// Result register stage
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module lprp_out_stage import lprp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     result_i,
  output logic        space_o,
  lprp_out_if.source  result_o
);

  logic    valid_q;
  logic    valid_d;
  result_t result_q;

  assign space_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign result_o.valid           = valid_q;
  assign result_o.byte_role       = result_q.byte_role;
  assign result_o.byte_out        = result_q.byte_out;
  assign result_o.record_complete = result_q.record_complete;
  assign result_o.entry_type      = result_q.entry_type;
  assign result_o.sequence_number = result_q.sequence_number;
  assign result_o.key_length      = result_q.key_length;
  assign result_o.value_length    = result_q.value_length;
  assign result_o.block_done      = result_q.block_done;
  assign result_o.partial_dropped = result_q.partial_dropped;

endmodule

// File: rtl/length_prefixed_record_parser.sv
// ----------------------------------------------------------------------------
// Length-prefixed record parser
// A byte item is held in the input register, its result in the result register.
// Throughput: one byte item per cycle while the result side is not stalled.
// Reset: rst_ni clears both stage valid flags and returns the parser to the
// key length phase with all record fields zero.
// ----------------------------------------------------------------------------
module length_prefixed_record_parser import lprp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lprp_in_if.sink    item_i,
  lprp_out_if.source result_o
);

  logic     in_valid;
  in_item_t in_item;
  logic     out_space;
  logic     advance;
  result_t  result;

  // An item moves from the input register into the result register when the
  // result register is empty or is being emptied in this cycle.
  assign advance = in_valid && out_space;

  lprp_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .take_i  (advance),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  lprp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item),
    .result_o  (result)
  );

  lprp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .space_o  (out_space),
    .result_o (result_o)
  );

endmodule

// File: verif/lprp_record_checker.sv
// ----------------------------------------------------------------------------
// Record parser checker
// Watches the byte and result channels, keeps its own copy of the parser state,
// predicts one result item per accepted byte item and compares them in order.
// ----------------------------------------------------------------------------
module lprp_record_checker import lprp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lprp_in_if   item_mon,
  lprp_out_if  result_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   bytes_checked_o,
  output int   records_seen_o,
  output int   drops_seen_o
);

  // Parser state as the block should hold it.
  logic [RoleW-1:0] parse_phase;
  logic [3:0]       field_count;
  logic [LenW-1:0]  bytes_left;
  logic [LenW-1:0]  key_len;
  logic [ByteW-1:0] entry_byte;
  logic [SeqW-1:0]  seq_num;
  logic [LenW-1:0]  val_len;

  result_t byte_reports_q[$];
  int      mismatches;
  int      bytes_checked;
  int      records_seen;
  int      drops_seen;

  assign fail_count_o    = mismatches;
  assign bytes_checked_o = bytes_checked;
  assign records_seen_o  = records_seen;
  assign drops_seen_o    = drops_seen;

  function automatic void clear_record();
    parse_phase = PH_KLEN;
    field_count = '0;
    bytes_left  = '0;
    key_len     = '0;
    entry_byte  = '0;
    seq_num     = '0;
    val_len     = '0;
  endfunction

  // Advances the parser by one byte and returns the report that byte must give.
  function automatic result_t decode_byte(logic [ByteW-1:0] b, logic last);
    result_t r;
    logic    done;
    r    = '0;
    done = 1'b0;
    if (parse_phase > PH_VAL) parse_phase = PH_KLEN;
    r.byte_role = parse_phase;
    case (parse_phase)
      PH_KLEN: begin
        key_len     = key_len | (LenW'(b) << (8 * field_count[1:0]));
        field_count = field_count + 4'd1;
        if (field_count >= 4'd4) begin
          field_count = '0;
          bytes_left  = key_len;
          parse_phase = (key_len == '0) ? PH_TYPE : PH_KEY;
        end
      end
      PH_KEY: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) parse_phase = PH_TYPE;
      end
      PH_TYPE: begin
        entry_byte  = b;
        field_count = '0;
        parse_phase = PH_SEQ;
      end
      PH_SEQ: begin
        seq_num     = seq_num | (SeqW'(b) << (8 * field_count[2:0]));
        field_count = field_count + 4'd1;
        if (field_count >= 4'd8) begin
          field_count = '0;
          parse_phase = PH_VLEN;
        end
      end
      PH_VLEN: begin
        val_len     = val_len | (LenW'(b) << (8 * field_count[1:0]));
        field_count = field_count + 4'd1;
        if (field_count >= 4'd4) begin
          field_count = '0;
          bytes_left  = val_len;
          if (val_len == '0) done = 1'b1;
          else parse_phase = PH_VAL;
        end
      end
      default: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) done = 1'b1;
      end
    endcase
    r.byte_out        = b;
    r.record_complete = done;
    if (done) begin
      r.entry_type      = entry_byte;
      r.sequence_number = seq_num;
      r.key_length      = key_len;
      r.value_length    = val_len;
    end
    r.block_done      = last;
    r.partial_dropped = last && !done;
    if (done || last) clear_record();
    return r;
  endfunction

  function automatic void compare_field(string name, logic [SeqW-1:0] want,
                                        logic [SeqW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_record();
      byte_reports_q.delete();
      mismatches    = 0;
      bytes_checked = 0;
      records_seen  = 0;
      drops_seen    = 0;
      pending_o    <= 0;
    end else begin
      if (item_mon.valid && item_mon.ready) begin
        byte_reports_q = {byte_reports_q,
                          decode_byte(item_mon.data_byte, item_mon.last_byte)};
      end
      if (result_mon.valid && result_mon.ready) begin
        if (byte_reports_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual role %0d byte %0h",
                   $time, result_mon.byte_role, result_mon.byte_out);
          mismatches++;
        end else begin
          want = byte_reports_q.pop_front();
          compare_field("byte_role", SeqW'(want.byte_role),
                        SeqW'(result_mon.byte_role));
          compare_field("byte_out", SeqW'(want.byte_out), SeqW'(result_mon.byte_out));
          compare_field("record_complete", SeqW'(want.record_complete),
                        SeqW'(result_mon.record_complete));
          compare_field("entry_type", SeqW'(want.entry_type),
                        SeqW'(result_mon.entry_type));
          compare_field("sequence_number", want.sequence_number,
                        result_mon.sequence_number);
          compare_field("key_length", SeqW'(want.key_length),
                        SeqW'(result_mon.key_length));
          compare_field("value_length", SeqW'(want.value_length),
                        SeqW'(result_mon.value_length));
          compare_field("block_done", SeqW'(want.block_done),
                        SeqW'(result_mon.block_done));
          compare_field("partial_dropped", SeqW'(want.partial_dropped),
                        SeqW'(result_mon.partial_dropped));
          bytes_checked++;
          if (want.record_complete) records_seen++;
          if (want.partial_dropped) drops_seen++;
        end
      end
      pending_o <= byte_reports_q.size();
    end
  end

endmodule

// File: verif/length_prefixed_record_parser_test.sv
// ----------------------------------------------------------------------------
// Record parser testbench
// Feeds data blocks of well-formed, truncated and random records through the
// parser with random gaps and stalls on both channels; a checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module length_prefixed_record_parser_test;
  import lprp_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned ItemTarget = 1950;
  localparam int unsigned HoldOffAt  = 600;
  localparam int unsigned HoldOffLen = 250;

  typedef logic [ByteW-1:0] byte_q_t[$];

  logic clk_i;
  logic rst_ni;

  lprp_in_if  item_if();
  lprp_out_if result_if();

  int          fail_count;
  int          pending;
  int          bytes_checked;
  int          records_seen;
  int          drops_seen;
  int          sent_count;
  int          block_count;
  int unsigned cycle_count;
  logic        gapless_block;

  length_prefixed_record_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if)
  );

  lprp_record_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_mon        (item_if),
    .result_mon      (result_if),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .bytes_checked_o (bytes_checked),
    .records_seen_o  (records_seen),
    .drops_seen_o    (drops_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles with %0d result items outstanding",
             cycle_count, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 24);
    return $urandom_range(25, 60);
  endfunction

  function automatic void push_word(ref byte_q_t q, input logic [LenW-1:0] w);
    for (int i = 0; i < 4; i++) q = {q, w[8*i +: 8]};
  endfunction

  function automatic void add_record(ref byte_q_t q, input int unsigned klen,
                                     input int unsigned vlen,
                                     input logic [ByteW-1:0] etype,
                                     input logic [SeqW-1:0] seq);
    push_word(q, klen);
    for (int unsigned i = 0; i < klen; i++) q = {q, ByteW'($urandom)};
    q = {q, etype};
    for (int i = 0; i < 8; i++) q = {q, seq[8*i +: 8]};
    push_word(q, vlen);
    for (int unsigned i = 0; i < vlen; i++) q = {q, ByteW'($urandom)};
  endfunction

  function automatic void add_random_record(ref byte_q_t q);
    add_record(q, pick_len(), pick_len(), ByteW'($urandom), {$urandom, $urandom});
  endfunction

  task automatic push_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    gap = gapless_block ? 0 : idle_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.data_byte <= b;
    item_if.last_byte <= last;
    do @(posedge clk_i); while (!item_if.ready);
    sent_count++;
  endtask

  task automatic send_block(input byte_q_t q);
    gapless_block = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < q.size(); i++) push_byte(q[i], i == q.size() - 1);
    block_count++;
  endtask

  // Result side: random stalls, stretches of steady acceptance, and one long
  // hold-off while the byte side keeps offering items.
  initial begin
    int   stall;
    int   steady;
    int   r;
    logic held_off;
    stall    = 0;
    steady   = 0;
    held_off = 1'b0;
    result_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_off && sent_count >= HoldOffAt) begin
        held_off = 1'b1;
        result_if.ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk_i);
      end else if (steady > 0) begin
        steady--;
        result_if.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        result_if.ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) steady = $urandom_range(40, 120);
        else if (r < 25) stall = $urandom_range(0, 2);
        else if (r < 28) stall = $urandom_range(10, 40);
        result_if.ready <= (r >= 25 || r < 5);
      end
    end
  end

  initial begin
    byte_q_t blk;
    int      kind;
    int      cut;
    logic [LenW-1:0] big_len;
    sent_count    = 0;
    block_count   = 0;
    gapless_block = 1'b0;
    rst_ni             = 1'b0;
    item_if.valid     <= 1'b0;
    item_if.data_byte <= '0;
    item_if.last_byte <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero key and value lengths, maximum sequence, block ends on the record.
    blk = {};
    add_record(blk, 0, 0, 8'h00, '1);
    send_block(blk);
    // All-ones key length, cut short inside the key.
    blk = {8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    send_block(blk);
    // A block of a single byte ends inside the key length.
    blk = {8'h00};
    send_block(blk);

    while (sent_count < ItemTarget) begin
      blk  = {};
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 24)) blk = {blk, ByteW'($urandom)};
      end else if (kind == 1) begin
        // Huge key length; the block ends long before the key does.
        big_len = $urandom;
        if (big_len < 64) big_len = big_len + 64;
        push_word(blk, big_len);
        repeat ($urandom_range(0, 12)) blk = {blk, ByteW'($urandom)};
      end else if (kind == 2) begin
        repeat ($urandom_range(1, 2)) add_random_record(blk);
        cut = $urandom_range(1, blk.size() - 1);
        blk = blk[0:cut-1];
      end else begin
        repeat ($urandom_range(1, 4)) add_random_record(blk);
      end
      send_block(blk);
    end
    item_if.valid <= 1'b0;

    // One more edge so that the count includes the last accepted byte item.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d byte items in %0d blocks: %0d records completed, %0d dropped",
             bytes_checked, block_count, records_seen, drops_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lprp_pkg.sv
rtl/lprp_in_if.sv
rtl/lprp_out_if.sv
rtl/lprp_in_stage.sv
rtl/lprp_parser.sv
rtl/lprp_out_stage.sv
rtl/length_prefixed_record_parser.sv
verif/lprp_record_checker.sv
verif/length_prefixed_record_parser_test.sv
